### hdl/u2u8_pkg.sv
// Shared types, constants and encoding functions for the UTF-16 to UTF-8 encoder.
package u2u8_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CP_W        = 21;

   localparam logic [15:0] SUR_HI_FIRST = 16'hD800;
   localparam logic [15:0] SUR_HI_LAST  = 16'hDBFF;
   localparam logic [15:0] SUR_LO_FIRST = 16'hDC00;
   localparam logic [15:0] SUR_LO_LAST  = 16'hDFFF;
   localparam logic [9:0]  TEN_BITS     = 10'h3FF;
   localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // Work for one input transfer: one or two code points to encode.
   typedef struct packed {
      logic            two;
      logic [CP_W-1:0] cp_a;
      logic [CP_W-1:0] cp_b;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [2:0] enc_len(input logic [CP_W-1:0] cp);
      logic [2:0] len;
      if (cp <= 21'h7F) begin
         len = LEN_ONE;
      end else if (cp <= 21'h7FF) begin
         len = LEN_TWO;
      end else if (cp <= 21'hFFFF) begin
         len = LEN_THREE;
      end else begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

   function automatic logic [7:0] enc_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (enc_len(cp))
         LEN_ONE: begin
            b = {1'b0, cp[6:0]};
         end
         LEN_TWO: begin
            b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         end
         LEN_THREE: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

### hdl/u2u8_if.sv
// Handshake interfaces for the code unit and byte channels.
interface u2u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        final_unit;

   modport source (output valid, output code_unit, output final_unit, input ready);
   modport sink (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u2u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;

   modport source (output valid, output out_byte, output run_end, input ready);
   modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

### hdl/u2u8_front.sv
// Front end: accepts code units, tracks a pending high surrogate and builds jobs.
module u2u8_front
   import u2u8_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   u2u8_req_if.sink       req_bus,
   input  queue_stat_type q_stat,
   output logic           push,
   output job_type        push_job
);

   logic [9:0] lead_bits_ff, lead_bits_in;
   logic       lead_valid_ff, lead_valid_in;
   logic       accept, is_hi, is_lo;
   logic [15:0] unit;

   assign req_bus.ready = !q_stat.full;
   assign accept = req_bus.valid && req_bus.ready;
   assign unit   = req_bus.code_unit;
   assign is_hi  = (unit >= SUR_HI_FIRST) && (unit <= SUR_HI_LAST);
   assign is_lo  = (unit >= SUR_LO_FIRST) && (unit <= SUR_LO_LAST);

   always_comb begin
      lead_bits_in  = lead_bits_ff;
      lead_valid_in = lead_valid_ff;
      push          = 1'b0;
      push_job.two  = 1'b0;
      push_job.cp_a = {5'd0, unit};
      push_job.cp_b = {5'd0, unit};
      if (accept) begin
         if (lead_valid_ff && is_lo) begin
            push          = 1'b1;
            push_job.cp_a = {1'b0, lead_bits_ff, unit[9:0]} + SUPP_BASE;
            lead_valid_in = 1'b0;
            lead_bits_in  = 10'd0;
         end else if (lead_valid_ff) begin
            push          = 1'b1;
            push_job.cp_a = {5'd0, SUR_HI_FIRST | {6'd0, lead_bits_ff}};
            if (is_hi && !req_bus.final_unit) begin
               lead_bits_in  = unit[9:0] & TEN_BITS;
               lead_valid_in = 1'b1;
            end else begin
               push_job.two  = 1'b1;
               lead_bits_in  = 10'd0;
               lead_valid_in = 1'b0;
            end
         end else if (is_hi && !req_bus.final_unit) begin
            lead_bits_in  = unit[9:0] & TEN_BITS;
            lead_valid_in = 1'b1;
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_bits_ff  <= 10'd0;
         lead_valid_ff <= 1'b0;
      end else begin
         lead_bits_ff  <= lead_bits_in;
         lead_valid_ff <= lead_valid_in;
      end
   end

endmodule

### hdl/u2u8_queue.sv
// Short job queue between the front end and the byte emitter.
module u2u8_queue
   import u2u8_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  job_type        push_job,
   input  logic           pop,
   output job_type        pop_job,
   output queue_stat_type q_stat
);

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_job      = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

### hdl/u2u8_back.sv
// Back end: encodes queued code points and sends one byte per transfer.
module u2u8_back
   import u2u8_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  job_type        pop_job,
   input  queue_stat_type q_stat,
   output logic           pop,
   u2u8_rsp_if.source     rsp_bus
);

   logic            busy_ff, busy_in;
   logic            two_ff, two_in;
   logic            seg_ff, seg_in;
   logic [1:0]      idx_ff, idx_in;
   logic [CP_W-1:0] cp_a_ff, cp_a_in, cp_b_ff, cp_b_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_end_ff, rsp_end_in;
   logic [CP_W-1:0] cur_cp;
   logic [2:0]      cur_len;
   logic            out_free, emit, seg_done, job_done;

   assign cur_cp   = seg_ff ? cp_b_ff : cp_a_ff;
   assign cur_len  = enc_len(cur_cp);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = busy_ff && out_free;
   assign seg_done = ({1'b0, idx_ff} == (cur_len - 3'd1));
   assign job_done = seg_done && (seg_ff == two_ff);
   assign pop      = !q_stat.empty && (!busy_ff || (emit && job_done));

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.run_end  = rsp_end_ff;

   always_comb begin
      busy_in      = busy_ff;
      two_in       = two_ff;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      cp_a_in      = cp_a_ff;
      cp_b_in      = cp_b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = enc_byte(cur_cp, idx_ff);
         rsp_end_in   = job_done;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         busy_in = 1'b1;
         two_in  = pop_job.two;
         seg_in  = 1'b0;
         idx_in  = 2'd0;
         cp_a_in = pop_job.cp_a;
         cp_b_in = pop_job.cp_b;
      end else if (emit) begin
         if (job_done) begin
            busy_in = 1'b0;
         end else if (seg_done) begin
            seg_in = 1'b1;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      two_ff      <= two_in;
      seg_ff      <= seg_in;
      idx_ff      <= idx_in;
      cp_a_ff     <= cp_a_in;
      cp_b_ff     <= cp_b_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

endmodule

### hdl/utf16_to_utf8_encoder_top.sv
// Top level of the UTF-16 to UTF-8 encoder.
// A code unit's first byte goes through the job queue, the back-end job registers and the
// output byte register. Throughput is one byte per cycle while the byte channel is ready,
// set by the single output byte register; a unit yields zero to six bytes (zero if held).
// A four-entry job queue lets new units be taken while earlier bytes still go out.
// Synchronous reset clears the pending surrogate, the queue and the output valid flag.
module utf16_to_utf8_encoder_top
   import u2u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   u2u8_req_if.sink    req_bus,
   u2u8_rsp_if.source  rsp_bus
);

   logic           push, pop;
   job_type        push_job, pop_job;
   queue_stat_type q_stat;

   u2u8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_stat   (q_stat),
      .push     (push),
      .push_job (push_job)
   );

   u2u8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_stat   (q_stat)
   );

   u2u8_back u_back (
      .clock   (clock),
      .reset   (reset),
      .pop_job (pop_job),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

### tb/u2u8_checker.sv
// Checker that predicts the UTF-8 byte stream from observed code unit transfers and compares it.
module u2u8_checker
   import u2u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_final_unit,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_end,
   output int          mismatch_count,
   output int          bytes_owed
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } utf8_byte_type;

   utf8_byte_type owed_bytes[$];
   logic [9:0] lead_bits;
   logic       lead_held;
   int         fails;

   function automatic void push_byte(input logic [7:0] b);
      utf8_byte_type item;
      item.out_byte = b;
      item.run_end  = 1'b0;
      owed_bytes.push_back(item);
   endfunction

   function automatic void queue_code_point(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         push_byte({1'b0, cp[6:0]});
      end else if (cp <= 21'h7FF) begin
         push_byte(8'hC0 | {3'b000, cp[10:6]});
         push_byte(8'h80 | {2'b00, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
         push_byte(8'hE0 | {4'h0, cp[15:12]});
         push_byte(8'h80 | {2'b00, cp[11:6]});
         push_byte(8'h80 | {2'b00, cp[5:0]});
      end else begin
         push_byte(8'hF0 | {5'b00000, cp[20:18]});
         push_byte(8'h80 | {2'b00, cp[17:12]});
         push_byte(8'h80 | {2'b00, cp[11:6]});
         push_byte(8'h80 | {2'b00, cp[5:0]});
      end
   endfunction

   function automatic void predict_unit(input logic [15:0] unit, input logic last);
      logic        is_hi;
      logic        is_lo;
      logic [20:0] cp;
      int          base;
      is_hi = (unit >= SUR_HI_FIRST) && (unit <= SUR_HI_LAST);
      is_lo = (unit >= SUR_LO_FIRST) && (unit <= SUR_LO_LAST);
      base  = owed_bytes.size();
      if (lead_held && is_lo) begin
         cp = {1'b0, lead_bits, unit[9:0]} + 21'h10000;
         lead_held = 1'b0;
         lead_bits = 10'd0;
         queue_code_point(cp);
      end else begin
         if (lead_held) begin
            queue_code_point({5'd0, SUR_HI_FIRST | {6'd0, lead_bits}});
            lead_held = 1'b0;
            lead_bits = 10'd0;
         end
         if (is_hi && !last) begin
            lead_bits = unit[9:0];
            lead_held = 1'b1;
         end else begin
            queue_code_point({5'd0, unit});
         end
      end
      if (owed_bytes.size() > base) begin
         owed_bytes[owed_bytes.size() - 1].run_end = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      utf8_byte_type want;
      if (reset) begin
         owed_bytes.delete();
         lead_bits = 10'd0;
         lead_held = 1'b0;
         fails     = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_unit(req_code_unit, req_final_unit);
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_bytes.size() == 0) begin
               $display("%0t: unexpected byte transfer: expected none, actual byte %h run_end %b",
                        $time, rsp_out_byte, rsp_run_end);
               fails = fails + 1;
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $time, want.out_byte, rsp_out_byte);
                  fails = fails + 1;
               end
               if (rsp_run_end !== want.run_end) begin
                  $display("%0t: run_end mismatch: expected %b, actual %b",
                           $time, want.run_end, rsp_run_end);
                  fails = fails + 1;
               end
            end
         end
      end
      mismatch_count <= fails;
      bytes_owed     <= owed_bytes.size();
   end

endmodule

### tb/tb_utf16_to_utf8_encoder_top.sv
// Testbench top: drives code units and byte-channel backpressure and reports the verdict.
module tb_utf16_to_utf8_encoder_top;
   import u2u8_pkg::*;

   localparam int STUCK_LIMIT = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic no_idle = 1'b0;
   int   mismatch_count;
   int   bytes_owed;
   int   stuck_cycles;

   u2u8_req_if req_ch ();
   u2u8_rsp_if rsp_ch ();

   utf16_to_utf8_encoder_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   u2u8_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_code_unit  (req_ch.code_unit),
      .req_final_unit (req_ch.final_unit),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_out_byte   (rsp_ch.out_byte),
      .rsp_run_end    (rsp_ch.run_end),
      .mismatch_count (mismatch_count),
      .bytes_owed     (bytes_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_wait();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic send_unit(input logic [15:0] unit, input logic last);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.code_unit  <= unit;
      req_ch.final_unit <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_bytes();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (bytes_owed != 0);
   endtask

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = pick_wait();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      int         sent;
      int         kind;
      logic       paused;
      logic       last;
      logic [15:0] hi;
      req_ch.valid      <= 1'b0;
      req_ch.code_unit  <= 16'h0000;
      req_ch.final_unit <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b1);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hD7FF, 1'b0);
      send_unit(16'hE000, 1'b0);
      send_unit(16'hFFFF, 1'b1);
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'hD812, 1'b0);
      send_unit(16'hDA34, 1'b0);
      send_unit(16'hDC56, 1'b0);
      send_unit(16'hDAAA, 1'b1);
      send_unit(16'hDE00, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      send_unit(16'hD900, 1'b0);
      send_unit(16'hDB00, 1'b1);
      send_unit(16'hD955, 1'b0);
      send_unit(16'h0041, 1'b1);
      send_unit(16'h5555, 1'b0);

      sent   = 0;
      paused = 1'b0;
      while (sent < 450) begin
         if ((sent % 60) == 0) begin
            no_idle = ($urandom_range(0, 2) == 0);
         end
         if (!paused && (sent >= 200)) begin
            paused = 1'b1;
            drain_bytes();
         end
         last = ($urandom_range(0, 7) == 0);
         kind = $urandom_range(0, 19);
         if (kind < 8) begin
            hi = 16'($urandom_range(16'hD800, 16'hDBFF));
            send_unit(hi, 1'b0);
            send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
            sent = sent + 2;
         end else begin
            case (kind)
               8, 9, 10: send_unit(16'($urandom_range(16'h0000, 16'h007F)), last);
               11, 12:   send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
               13:       send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), last);
               14:       send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
               15, 16:   send_unit(16'($urandom_range(0, 16'hFFFF)), last);
               17:       send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), last);
               default:  send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
            endcase
            sent = sent + 1;
         end
      end

      drain_bytes();
      repeat (20) @(posedge clock);
      if ((mismatch_count == 0) && (bytes_owed == 0)) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/u2u8_pkg.sv
hdl/u2u8_if.sv
hdl/u2u8_front.sv
hdl/u2u8_queue.sv
hdl/u2u8_back.sv
hdl/utf16_to_utf8_encoder_top.sv
tb/u2u8_checker.sv
tb/tb_utf16_to_utf8_encoder_top.sv
